### rtl/aabb_cube_face_culler_defines.svh
// Assertion helpers for the cube face culler.
`ifndef AABB_CUBE_FACE_CULLER_DEFINES_SVH
`define AABB_CUBE_FACE_CULLER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of i_clk, muted while i_rst_n is low.
`define ACFC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("acfc assertion failed");
// Same, with the reset term also checked.
`define ACFC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("acfc assertion failed");
`else
`define ACFC_ASSERT(lbl, prop)
`define ACFC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/acfc_pkg.sv
package acfc_pkg;

    typedef struct packed {
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic [15:0]        object_flags;
        logic [31:0]        object_id;
    } t_in;

    typedef struct packed {
        logic [31:0] result_id;
        logic [15:0] result_depth;
        logic [2:0]  face_index;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic signed [2:0][31:0] light_min;
        logic signed [2:0][31:0] light_max;
        logic [15:0]             required_mask;
    } t_cfg;

    // sideband that rides the pipeline next to the arithmetic
    typedef struct packed {
        logic [31:0] id;
        logic [5:0]  mask;
    } t_side;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sqrt;

    localparam logic [3:0] REG_LIGHT_MIN_X   = 4'd0;
    localparam logic [3:0] REG_LIGHT_MIN_Y   = 4'd1;
    localparam logic [3:0] REG_LIGHT_MIN_Z   = 4'd2;
    localparam logic [3:0] REG_LIGHT_MAX_X   = 4'd3;
    localparam logic [3:0] REG_LIGHT_MAX_Y   = 4'd4;
    localparam logic [3:0] REG_LIGHT_MAX_Z   = 4'd5;
    localparam logic [3:0] REG_DEPTH_SCALE   = 4'd6;
    localparam logic [3:0] REG_REQUIRED_MASK = 4'd7;

    localparam logic [31:0] DEPTH_SCALE_RST = 32'd65536;
    localparam logic [15:0] DEPTH_MAX       = 16'hFFFF;
    localparam int          SQRT_STEPS      = 4;
    localparam int          SQRT_STAGES     = 8;

    // one restoring digit of the square root: two radicand bits in, one root bit out
    function automatic t_sqrt sqrt_step(t_sqrt s);
        t_sqrt       r;
        logic [34:0] rs;
        logic [34:0] tr;
        rs    = {s.rem[32:0], s.rad[63:62]};
        tr    = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[61:0], 2'b00};
        if (rs >= tr) begin
            r.rem  = rs - tr;
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = rs;
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### rtl/aabb_cube_face_culler.sv
// Point-light cube-face culler. Takes one object box per transaction (i_in_*),
// drops it unless its flags carry every bit of required_mask and the box
// overlaps the light box (inclusive), and otherwise returns one transaction per
// cube face that sees it (o_out_*), in face order 0..5 with last_of_run on the
// final one; an object that is not cullable gets all six faces. A new object
// can be taken every cycle while the output does not stall; the pipeline is 14
// register stages from input to the output register (two geometry stages,
// square, sum, eight square-root stages of four digits each, depth multiply,
// output). The output register sends one face per cycle while i_out_ready is
// high, so an object holds it until its last face is taken, and the input
// stalls behind it. Configuration writes (i_cfg_*) are always taken, index 0..7
// in register order; other indices are ignored.
`include "aabb_cube_face_culler_defines.svh"

module aabb_cube_face_culler #(
    parameter int FLAG_BITS    = 16,
    parameter int CULLABLE_BIT = 0,
    parameter int ID_BITS      = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  acfc_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output acfc_pkg::t_out    o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [3:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    // configuration registers
    logic signed [2:0][31:0] r_light_min;
    logic signed [2:0][31:0] r_light_max;
    logic [31:0]             r_depth_scale;
    logic [15:0]             r_req_mask;
    acfc_pkg::t_cfg          cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_min   <= '0;
            r_light_max   <= '0;
            r_depth_scale <= acfc_pkg::DEPTH_SCALE_RST;
            r_req_mask    <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                acfc_pkg::REG_LIGHT_MIN_X:   r_light_min[0] <= i_cfg_data;
                acfc_pkg::REG_LIGHT_MIN_Y:   r_light_min[1] <= i_cfg_data;
                acfc_pkg::REG_LIGHT_MIN_Z:   r_light_min[2] <= i_cfg_data;
                acfc_pkg::REG_LIGHT_MAX_X:   r_light_max[0] <= i_cfg_data;
                acfc_pkg::REG_LIGHT_MAX_Y:   r_light_max[1] <= i_cfg_data;
                acfc_pkg::REG_LIGHT_MAX_Z:   r_light_max[2] <= i_cfg_data;
                acfc_pkg::REG_DEPTH_SCALE:   r_depth_scale  <= i_cfg_data;
                acfc_pkg::REG_REQUIRED_MASK: r_req_mask     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.light_min     = r_light_min;
    assign cfg.light_max     = r_light_max;
    assign cfg.required_mask = r_req_mask;

    // whole pipeline moves together; only the output register can hold it
    logic adv;
    assign o_in_ready = adv;

    // stages 1-2: gating, plane tests, face mask, centre magnitudes (Q.15)
    logic             f_vld;
    acfc_pkg::t_side  f_side;
    logic [2:0][30:0] f_mag;

    acfc_front #(
        .FLAG_BITS    (FLAG_BITS),
        .CULLABLE_BIT (CULLABLE_BIT),
        .ID_BITS      (ID_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (cfg),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_mag   (f_mag)
    );

    // stage 3: squares
    logic             r3_vld;
    acfc_pkg::t_side  r3_side;
    logic [2:0][61:0] r3_sq;

    // stage 4: sum of squares, loaded as the square-root radicand
    logic             r4_vld;
    acfc_pkg::t_side  r4_side;
    acfc_pkg::t_sqrt  r4_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= f_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_side <= f_side;
            for (int a = 0; a < 3; a++) begin
                r3_sq[a] <= 62'(f_mag[a]) * 62'(f_mag[a]);
            end
            r4_side    <= r3_side;
            r4_st.rem  <= 35'd0;
            r4_st.root <= 32'd0;
            r4_st.rad  <= 64'(r3_sq[0]) + 64'(r3_sq[1]) + 64'(r3_sq[2]);
        end
    end

    // square-root pipeline
    logic            s_vld  [acfc_pkg::SQRT_STAGES + 1];
    acfc_pkg::t_side s_side [acfc_pkg::SQRT_STAGES + 1];
    acfc_pkg::t_sqrt s_st   [acfc_pkg::SQRT_STAGES + 1];

    assign s_vld[0]  = r4_vld;
    assign s_side[0] = r4_side;
    assign s_st[0]   = r4_st;

    for (genvar g = 0; g < acfc_pkg::SQRT_STAGES; g++) begin : g_sqrt
        acfc_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_vld   (s_vld[g]),
            .i_side  (s_side[g]),
            .i_st    (s_st[g]),
            .o_vld   (s_vld[g + 1]),
            .o_side  (s_side[g + 1]),
            .o_st    (s_st[g + 1])
        );
    end

    // depth multiply: root (Q.15) times scale (Q16.16), result >> 31
    logic            r_m_vld;
    acfc_pkg::t_side r_m_side;
    logic [63:0]     r_m_prod;
    logic [15:0]     depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (adv) begin
            r_m_vld <= s_vld[acfc_pkg::SQRT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_side <= s_side[acfc_pkg::SQRT_STAGES];
            r_m_prod <= 64'(s_st[acfc_pkg::SQRT_STAGES].root) * 64'(r_depth_scale);
        end
    end

    assign depth = (r_m_prod[63:47] != 17'd0) ? acfc_pkg::DEPTH_MAX : r_m_prod[46:31];

    acfc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (r_m_vld),
        .i_side      (r_m_side),
        .i_depth     (depth),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `ACFC_ASSERT(a_front_mask, f_vld |-> (f_side.mask != 6'd0))
    `ACFC_ASSERT(a_hold_sq, !adv |=> $stable(r4_st.rad))
    `ACFC_ASSERT(a_sqrt_digits, r4_vld |-> (r4_st.root == 32'd0))

endmodule

### rtl/acfc_front.sv
module acfc_front #(
    parameter int FLAG_BITS    = 16,
    parameter int CULLABLE_BIT = 0,
    parameter int ID_BITS      = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  acfc_pkg::t_in         i_data,
    input  acfc_pkg::t_cfg        i_cfg,
    output logic                  o_vld,
    output acfc_pkg::t_side       o_side,
    output logic [2:0][30:0]      o_mag
);

    localparam logic [15:0] FMASK  = (FLAG_BITS >= 16) ? 16'hFFFF
                                   : 16'((32'd1 << FLAG_BITS) - 32'd1);
    localparam logic [31:0] IDMASK = (ID_BITS >= 32) ? 32'hFFFF_FFFF
                                   : 32'((64'd1 << ID_BITS) - 64'd1);
    localparam bit          CULL_OK = (CULLABLE_BIT < FLAG_BITS) && (CULLABLE_BIT < 16);

    // stage 1: gate, centre and extent (doubled), face side tests
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
    logic signed [32:0] bsum [3];
    logic signed [32:0] lsum [3];
    logic signed [33:0] n_c2 [3];
    logic signed [32:0] n_e2 [3];
    logic signed [33:0] tmax [3];
    logic signed [33:0] tmin [3];
    logic [5:0]         n_sidebits;
    logic [15:0]        flags;
    logic [15:0]        req;
    logic               n_keep;

    logic               r1_vld;
    logic signed [33:0] r1_c2 [3];
    logic signed [32:0] r1_e2 [3];
    logic [5:0]         r1_sidebits;
    logic               r1_cull;
    logic [31:0]        r1_id;

    always_comb begin
        bmin[0] = i_data.box_min_x;
        bmin[1] = i_data.box_min_y;
        bmin[2] = i_data.box_min_z;
        bmax[0] = i_data.box_max_x;
        bmax[1] = i_data.box_max_y;
        bmax[2] = i_data.box_max_z;
        flags   = i_data.object_flags & FMASK;
        req     = i_cfg.required_mask & FMASK;
        n_keep  = ((flags & req) == req);
        for (int a = 0; a < 3; a++) begin
            bsum[a] = 33'(bmin[a]) + 33'(bmax[a]);
            lsum[a] = 33'($signed(i_cfg.light_min[a])) + 33'($signed(i_cfg.light_max[a]));
            n_c2[a] = 34'(bsum[a]) - 34'(lsum[a]);
            n_e2[a] = 33'(bmax[a]) - 33'(bmin[a]);
            tmax[a] = {bmax[a][31], bmax[a], 1'b0};
            tmin[a] = {bmin[a][31], bmin[a], 1'b0};
            if (!($signed(i_cfg.light_min[a]) <= bmax[a] &&
                  bmin[a] <= $signed(i_cfg.light_max[a]))) begin
                n_keep = 1'b0;
            end
            n_sidebits[2*a]     = tmax[a] > 34'(lsum[a]);
            n_sidebits[2*a + 1] = tmin[a] < 34'(lsum[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c2       <= n_c2;
            r1_e2       <= n_e2;
            r1_sidebits <= n_sidebits;
            r1_cull     <= CULL_OK ? flags[4'(CULLABLE_BIT)] : 1'b0;
            r1_id       <= i_data.object_id & IDMASK;
        end
    end

    // stage 2: plane tests, face mask, centre magnitudes
    logic signed [34:0] pdist [6];
    logic signed [33:0] rad  [6];
    logic [5:0]         rp;
    logic [5:0]         rn;
    logic [5:0]         vis;
    logic [5:0]         n_mask;
    logic [33:0]        mag  [3];
    logic [2:0][30:0]   n_mag;

    logic               r2_vld;
    acfc_pkg::t_side    r2_side;
    logic [2:0][30:0]   r2_mag;

    always_comb begin
        pdist[0] = 35'(r1_c2[1]) - 35'(r1_c2[0]);
        pdist[1] = 35'(r1_c2[0]) + 35'(r1_c2[1]);
        pdist[2] = 35'(r1_c2[0]) + 35'(r1_c2[2]);
        pdist[3] = 35'(r1_c2[0]) - 35'(r1_c2[2]);
        pdist[4] = 35'(r1_c2[1]) + 35'(r1_c2[2]);
        pdist[5] = 35'(r1_c2[2]) - 35'(r1_c2[1]);
        rad[0]  = 34'(r1_e2[0]) + 34'(r1_e2[1]);
        rad[1]  = rad[0];
        rad[2]  = 34'(r1_e2[0]) + 34'(r1_e2[2]);
        rad[3]  = rad[2];
        rad[4]  = 34'(r1_e2[1]) + 34'(r1_e2[2]);
        rad[5]  = rad[4];
        for (int j = 0; j < 6; j++) begin
            rp[j] = (36'(pdist[j]) + 36'(rad[j])) > 36'sd0;
            rn[j] = 36'(pdist[j]) < 36'(rad[j]);
        end
        vis[0] = rn[0] & rp[1] & rp[2] & rp[3] & r1_sidebits[0];
        vis[1] = rp[0] & rn[1] & rn[2] & rn[3] & r1_sidebits[1];
        vis[2] = rp[0] & rp[1] & rp[4] & rn[5] & r1_sidebits[2];
        vis[3] = rn[0] & rn[1] & rn[4] & rp[5] & r1_sidebits[3];
        vis[4] = rp[2] & rn[3] & rp[4] & rp[5] & r1_sidebits[4];
        vis[5] = rn[2] & rp[3] & rn[4] & rn[5] & r1_sidebits[5];
        n_mask = r1_cull ? vis : 6'h3F;
        for (int a = 0; a < 3; a++) begin
            mag[a]   = r1_c2[a][33] ? 34'(-r1_c2[a]) : 34'(r1_c2[a]);
            n_mag[a] = mag[a][32:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld && (n_mask != 6'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side.id   <= r1_id;
            r2_side.mask <= n_mask;
            r2_mag       <= n_mag;
        end
    end

    assign o_vld  = r2_vld;
    assign o_side = r2_side;
    assign o_mag  = r2_mag;

endmodule

### rtl/acfc_sqrt_stage.sv
module acfc_sqrt_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  acfc_pkg::t_side   i_side,
    input  acfc_pkg::t_sqrt   i_st,
    output logic              o_vld,
    output acfc_pkg::t_side   o_side,
    output acfc_pkg::t_sqrt   o_st
);

    acfc_pkg::t_sqrt n_st;
    logic            r_vld;
    acfc_pkg::t_side r_side;
    acfc_pkg::t_sqrt r_st;

    always_comb begin
        n_st = i_st;
        for (int k = 0; k < acfc_pkg::SQRT_STEPS; k++) begin
            n_st = acfc_pkg::sqrt_step(n_st);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_st   <= n_st;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_st   = r_st;

endmodule

### rtl/acfc_emit.sv
`include "aabb_cube_face_culler_defines.svh"

module acfc_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  acfc_pkg::t_side   i_side,
    input  logic [15:0]       i_depth,
    output logic              o_adv,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output acfc_pkg::t_out    o_out_data
);

    logic            r_vld;
    logic [5:0]      r_mask;
    logic [31:0]     r_id;
    logic [15:0]     r_depth;
    logic [2:0]      face;
    logic [5:0]      lowbit;
    logic            last;
    logic            take;

    always_comb begin
        face   = 3'd0;
        lowbit = 6'd0;
        for (int j = 5; j >= 0; j--) begin
            if (r_mask[j]) begin
                face   = 3'(j);
                lowbit = 6'd1 << j;
            end
        end
        last  = (r_mask & (r_mask - 6'd1)) == 6'd0;
        take  = r_vld && i_out_ready;
        o_adv = !r_vld || (take && last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_mask <= 6'd0;
        end else if (o_adv) begin
            r_vld  <= i_vld;
            r_mask <= i_side.mask;
        end else if (take) begin
            r_mask <= r_mask & ~lowbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_id    <= i_side.id;
            r_depth <= i_depth;
        end
    end

    assign o_out_valid             = r_vld;
    assign o_out_data.result_id    = r_id;
    assign o_out_data.result_depth = r_depth;
    assign o_out_data.face_index   = face;
    assign o_out_data.last_of_run  = last;

    `ACFC_ASSERT(a_mask_live, r_vld |-> (r_mask != 6'd0))
    `ACFC_ASSERT(a_run_goes_on, (take && !last) |=> (r_vld && $onehot0(r_mask ^ $past(r_mask))))
    `ACFC_ASSERT(a_stall_only_busy, !o_adv |-> r_vld)
    `ACFC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_vld)

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // clock / reset
    logic i_clk;
    logic i_rst_n;

    // object channel
    logic          i_in_valid;
    logic          o_in_ready;
    acfc_pkg::t_in i_in_data;

    // face result channel
    logic           o_out_valid;
    logic           i_out_ready;
    acfc_pkg::t_out o_out_data;

    // register write channel
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    aabb_cube_face_culler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // pipeline is 14 stages deep; drained objects may still be in flight
    localparam int PIPE_SETTLE = 24;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    // diagonal plane normals and their absolute components, one row per plane
    localparam int PLANE_N[6][3] = '{'{-1, 1, 0}, '{1, 1, 0}, '{1, 0, 1},
                                     '{1, 0, -1}, '{0, 1, 1}, '{0, -1, 1}};
    localparam int PLANE_A[6][3] = '{'{1, 1, 0}, '{1, 1, 0}, '{1, 0, 1},
                                     '{1, 0, 1}, '{0, 1, 1}, '{0, 1, 1}};

    // face codes
    localparam logic [2:0] FACE_BACK = 3'd5;

    // shadow copy of the register file
    logic signed [31:0] light_lo [3];
    logic signed [31:0] light_hi [3];
    logic [31:0]        depth_scale;
    logic [15:0]        req_mask;

    acfc_pkg::t_out face_q [$];        // faces still owed by the block
    int   n_mismatch;
    int   n_objects;
    int   n_faces;
    int   idle_cycles;
    int   in_idle_pct;
    int   out_idle_pct;
    bit   hold_req;

    // ---------------------------------------------------------------
    // clock
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // floor square root, bit-serial
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    // Works out the faces that see one object under the shadow registers
    // and queues them in face order.
    function automatic void predict_faces(acfc_pkg::t_in obj);
        longint          bmin [3];
        longint          bmax [3];
        longint          lo [3];
        longint          hi [3];
        longint          c2 [3];
        longint          e2 [3];
        longint          pdist;
        longint          rad;
        longint unsigned m;
        longint unsigned sq;
        longint unsigned dep;
        bit              rp [6];
        bit              rn [6];
        bit              vis [6];
        bit              cul;
        int              last;
        acfc_pkg::t_out  r;
        if ((obj.object_flags & req_mask) != req_mask) return;
        bmin[0] = obj.box_min_x; bmin[1] = obj.box_min_y; bmin[2] = obj.box_min_z;
        bmax[0] = obj.box_max_x; bmax[1] = obj.box_max_y; bmax[2] = obj.box_max_z;
        for (int a = 0; a < 3; a++) begin
            lo[a] = light_lo[a];
            hi[a] = light_hi[a];
            // inclusive overlap, inverted boxes taken as given
            if (!(lo[a] <= bmax[a] && bmin[a] <= hi[a])) return;
        end
        sq = 0;
        for (int a = 0; a < 3; a++) begin
            c2[a] = (bmin[a] + bmax[a]) - (lo[a] + hi[a]);
            e2[a] = bmax[a] - bmin[a];
            m = ((c2[a] < 0) ? -c2[a] : c2[a]) >> 2;
            sq += m * m;
        end
        dep = (floor_sqrt(sq) * longint'(depth_scale)) >> 31;
        if (dep > 64'hFFFF) dep = 64'hFFFF;
        for (int j = 0; j < 6; j++) begin
            pdist = 0;
            rad = 0;
            for (int a = 0; a < 3; a++) begin
                pdist += c2[a] * PLANE_N[j][a];
                rad += e2[a] * PLANE_A[j][a];
            end
            rp[j] = pdist > -rad;
            rn[j] = pdist < rad;
        end
        vis[0] = rn[0] && rp[1] && rp[2] && rp[3] && 2 * bmax[0] > lo[0] + hi[0];
        vis[1] = rp[0] && rn[1] && rn[2] && rn[3] && 2 * bmin[0] < lo[0] + hi[0];
        vis[2] = rp[0] && rp[1] && rp[4] && rn[5] && 2 * bmax[1] > lo[1] + hi[1];
        vis[3] = rn[0] && rn[1] && rn[4] && rp[5] && 2 * bmin[1] < lo[1] + hi[1];
        vis[4] = rp[2] && rn[3] && rp[4] && rp[5] && 2 * bmax[2] > lo[2] + hi[2];
        vis[5] = rn[2] && rp[3] && rn[4] && rn[5] && 2 * bmin[2] < lo[2] + hi[2];
        cul = obj.object_flags[0];
        last = -1;
        for (int j = 0; j < 6; j++) if (!cul || vis[j]) last = j;
        for (int j = 0; j < 6; j++) begin
            if (!cul || vis[j]) begin
                r.result_id    = obj.object_id;
                r.result_depth = dep[15:0];
                r.face_index   = 3'(j);
                r.last_of_run  = (j == last);
                face_q.push_back(r);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // result checker: every accepted face against the oldest owed one
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        acfc_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_faces++;
            if (face_q.size() == 0) begin
                n_mismatch++;
                $display("%0t: unexpected face, exp none got %h", $time, o_out_data);
            end else begin
                want = face_q.pop_front();
                if (o_out_data.result_id !== want.result_id) begin
                    n_mismatch++;
                    $display("%0t: result_id exp %h got %h", $time,
                             want.result_id, o_out_data.result_id);
                end
                if (o_out_data.result_depth !== want.result_depth) begin
                    n_mismatch++;
                    $display("%0t: result_depth exp %h got %h", $time,
                             want.result_depth, o_out_data.result_depth);
                end
                if (o_out_data.face_index !== want.face_index) begin
                    n_mismatch++;
                    $display("%0t: face_index exp %0d got %0d", $time,
                             want.face_index, o_out_data.face_index);
                end
                if (o_out_data.last_of_run !== want.last_of_run) begin
                    n_mismatch++;
                    $display("%0t: last_of_run exp %b got %b", $time,
                             want.last_of_run, o_out_data.last_of_run);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: cycles with no transaction on any channel
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d faces owed", $time, face_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    // one object transaction; called and returns at a falling edge
    task automatic send_object(acfc_pkg::t_in obj);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= obj;
        do @(posedge i_clk); while (!o_in_ready);
        predict_faces(obj);
        n_objects++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            acfc_pkg::REG_LIGHT_MIN_X, acfc_pkg::REG_LIGHT_MIN_Y,
            acfc_pkg::REG_LIGHT_MIN_Z:   light_lo[idx] = val;
            acfc_pkg::REG_LIGHT_MAX_X:   light_hi[0] = val;
            acfc_pkg::REG_LIGHT_MAX_Y:   light_hi[1] = val;
            acfc_pkg::REG_LIGHT_MAX_Z:   light_hi[2] = val;
            acfc_pkg::REG_DEPTH_SCALE:   depth_scale = val;
            acfc_pkg::REG_REQUIRED_MASK: req_mask = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_light(longint lo_v[3], longint hi_v[3],
                              logic [31:0] scale, logic [15:0] mask);
        write_reg(acfc_pkg::REG_LIGHT_MIN_X, 32'(lo_v[0]));
        write_reg(acfc_pkg::REG_LIGHT_MIN_Y, 32'(lo_v[1]));
        write_reg(acfc_pkg::REG_LIGHT_MIN_Z, 32'(lo_v[2]));
        write_reg(acfc_pkg::REG_LIGHT_MAX_X, 32'(hi_v[0]));
        write_reg(acfc_pkg::REG_LIGHT_MAX_Y, 32'(hi_v[1]));
        write_reg(acfc_pkg::REG_LIGHT_MAX_Z, 32'(hi_v[2]));
        write_reg(acfc_pkg::REG_DEPTH_SCALE, scale);
        write_reg(acfc_pkg::REG_REQUIRED_MASK, {16'h0, mask});
    endtask

    // sender pause: everything owed has come back and the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (face_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    // Random object: mostly a box near the light box whose flags carry the
    // mask, sometimes inverted; the rest is raw noise on every bit.
    function automatic acfc_pkg::t_in rand_object();
        acfc_pkg::t_in o;
        longint        bmin [3];
        longint        bmax [3];
        longint        span;
        if ($urandom_range(99) < 20) begin
            o = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 16'($urandom), $urandom};
            return o;
        end
        for (int a = 0; a < 3; a++) begin
            span = longint'(light_hi[a]) - longint'(light_lo[a]);
            if (span < 0) span = -span;
            span = span + 64'h20000;
            bmin[a] = longint'(light_lo[a]) - span / 2 +
                      longint'($urandom_range(32'hFFFF_FFFF)) % (span * 2);
            bmax[a] = bmin[a] + longint'($urandom_range(32'hFFFF_FFFF)) % span;
            if ($urandom_range(99) < 10) begin
                span = bmin[a];
                bmin[a] = bmax[a];
                bmax[a] = span;
            end
        end
        o.box_min_x = 32'(bmin[0]); o.box_min_y = 32'(bmin[1]);
        o.box_min_z = 32'(bmin[2]);
        o.box_max_x = 32'(bmax[0]); o.box_max_y = 32'(bmax[1]);
        o.box_max_z = 32'(bmax[2]);
        o.object_flags = 16'($urandom) | req_mask;
        o.object_id = $urandom;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // directed stimulus table
    // ---------------------------------------------------------------
    typedef struct {
        acfc_pkg::t_in obj;
        bit            typed;      // expectation typed in (reset registers only)
        bit            dropped;    // typed: no face at all
        logic [15:0]   depth;      // typed: all six faces at this depth
    } t_row;

    localparam int N_ROWS = 10;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;
    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    t_row rows [N_ROWS];

    initial begin
        longint         lo_v [3];
        longint         hi_v [3];
        acfc_pkg::t_out r;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        n_mismatch  = 0;
        n_objects   = 0;
        n_faces     = 0;
        idle_cycles = 0;
        in_idle_pct  = 12;
        out_idle_pct = 57;
        for (int a = 0; a < 3; a++) begin
            light_lo[a] = '0;
            light_hi[a] = '0;
        end
        depth_scale = acfc_pkg::DEPTH_SCALE_RST;
        req_mask    = '0;

        // point at the light centre, not cullable: six faces at depth 0
        rows[0] = '{'{0, 0, 0, 0, 0, 0, 16'h0000, 32'hFFFF_FFFF}, 1, 0, 16'd0};
        // full-range box: doubled centre is -1, under one depth unit
        rows[1] = '{'{QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, 16'hFFFE, 32'h0}, 1, 0, 16'd0};
        // cullable point at the centre
        rows[2] = '{'{0, 0, 0, 0, 0, 0, 16'h0001, 32'h1}, 0, 0, 16'd0};
        // misses the light box on x: dropped
        rows[3] = '{'{1, 0, 0, 5, 0, 0, 16'h0001, 32'h3}, 1, 1, 16'd0};
        // leaning right
        rows[4] = '{'{-ONE, -1, -1, 3 * ONE, 1, 1, 16'h0001, 32'h4}, 0, 0, 16'd0};
        // tall in +y
        rows[5] = '{'{-1, -ONE, -1, 1, 80 * ONE, 1, 16'h0001, 32'h5}, 0, 0, 16'd0};
        // deep in -z
        rows[6] = '{'{-1, -1, -90 * ONE, 1, 1, ONE, 16'h8001, 32'h6}, 0, 0, 16'd0};
        // inverted box
        rows[7] = '{'{ONE, 2 * ONE, ONE, -ONE, -ONE, -3 * ONE, 16'h0001, 32'h7},
                    0, 0, 16'd0};
        // far corner, saturates under a large depth scale
        rows[8] = '{'{0, 0, 0, QMAX, QMAX, QMAX, 16'h0000, 32'h8}, 0, 0, 16'd0};
        // negative corner, all flags set
        rows[9] = '{'{QMIN, QMIN, QMIN, 0, 0, 0, 16'hFFFF, 32'hA5A5_A5A5}, 0, 0, 16'd0};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // pass 1: registers as reset leaves them
        foreach (rows[k]) begin
            if (rows[k].typed) begin
                while ($urandom_range(99) < in_idle_pct) begin
                    i_in_valid <= 1'b0;
                    @(negedge i_clk);
                end
                i_in_valid <= 1'b1;
                i_in_data  <= rows[k].obj;
                do @(posedge i_clk); while (!o_in_ready);
                n_objects++;
                if (!rows[k].dropped) begin
                    for (int j = 0; j < 6; j++) begin
                        r.result_id    = rows[k].obj.object_id;
                        r.result_depth = rows[k].depth;
                        r.face_index   = 3'(j);
                        r.last_of_run  = (3'(j) == FACE_BACK);
                        face_q.push_back(r);
                    end
                end
                @(negedge i_clk);
            end else begin
                send_object(rows[k].obj);
            end
        end
        drain();

        // pass 2: wide light box, largest depth scale
        lo_v = '{-1000 * 65536, -1000 * 65536, -1000 * 65536};
        hi_v = '{1000 * 65536, 1000 * 65536, 1000 * 65536};
        load_light(lo_v, hi_v, 32'hFFFF_FFFF, 16'h0000);
        foreach (rows[k]) send_object(rows[k].obj);
        drain();

        // random phase 1: moderate light box, sender mostly busy, receiver lazy
        for (int a = 0; a < 3; a++) begin
            lo_v[a] = $signed(32'($urandom_range(32'h01FF_FFFF))) - 32'sh0100_0000;
            hi_v[a] = lo_v[a] + $urandom_range(32'h0040_0000, 32'h0001_0000);
        end
        load_light(lo_v, hi_v, $urandom, 16'($urandom) & 16'h0006);
        repeat (50) send_object(rand_object());
        drain();

        // random phase 2: whole-range light box, every flag required
        in_idle_pct  = 57;
        out_idle_pct = 12;
        lo_v = '{QMIN, QMIN, QMIN};
        hi_v = '{QMAX, QMAX, QMAX};
        load_light(lo_v, hi_v, 32'hFFFF_FFFF, 16'hFFFF);
        repeat (50) send_object(rand_object());
        drain();

        // random phase 3: no idling, zero depth scale, one long output hold-off
        in_idle_pct  = 0;
        out_idle_pct = 0;
        for (int a = 0; a < 3; a++) begin
            lo_v[a] = $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
            hi_v[a] = lo_v[a] + $urandom_range(32'h0020_0000);
        end
        load_light(lo_v, hi_v, 32'h0, 16'h0000);
        hold_req = 1'b1;
        repeat (50) send_object(rand_object());
        drain();

        $display("Covered %0d objects and %0d faces over five register settings,",
                 n_objects, n_faces);
        $display("with stalls on both sides, a long output hold-off and drains.");
        if (n_mismatch == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
